// ===== hw/rtl/hns_pkg.sv =====
// Package for the heightfield normal stencil: sizes, command type and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package hns_pkg;

  localparam int MAX_ROW     = 32;
  localparam int COORD_BITS  = 24;
  localparam int VEC_BITS    = COORD_BITS + 2;
  localparam int PTR_BITS    = 7;
  localparam int LEN_BITS    = 6;
  localparam int CNT_BITS    = 11;
  localparam int COL_BITS    = 5;
  localparam int ROW_BITS    = 10;
  localparam int MAG_BITS    = 14;
  localparam int UNIT_BITS   = 15;
  localparam int NRM_BITS    = 16;
  localparam int SUM_BITS    = 30;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  localparam logic [UNIT_BITS-1:0] ONE_Q14   = UNIT_BITS'(16384);
  localparam logic [LEN_BITS-1:0]  LEN_MIN   = LEN_BITS'(3);
  localparam logic [LEN_BITS-1:0]  LEN_MAX   = LEN_BITS'(MAX_ROW);
  localparam logic [CNT_BITS-1:0]  CNT_MIN   = CNT_BITS'(3);
  localparam logic [CNT_BITS-1:0]  CNT_MAX   = CNT_BITS'(1024);
  localparam logic [LEN_BITS-1:0]  LEN_RESET = LEN_BITS'(8);
  localparam logic [CNT_BITS-1:0]  CNT_RESET = CNT_BITS'(8);

  // register indexes of the configuration port
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_ROW_COUNT  = 1'b1;

  // one request from the front to the back
  typedef struct packed {
    logic                       up;    // edge vertex: straight up, no math
    logic signed [VEC_BITS-1:0] vx;
    logic signed [VEC_BITS-1:0] vy;
    logic signed [VEC_BITS-1:0] vz;
    logic                       last;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/heightfield_normal_stencil_top.sv =====
// Heightfield vertex normals: one unit normal per grid vertex, one row behind.
// Front: takes a new vertex only while idle, after the line store reads and the queue push of the last one.
// Back: per interior normal, range shifts to fit MAG_BITS, then squares and sum, then 15 trial steps;
// edge and zero vectors skip the math. It takes a new request only once the last result is registered out.
// Reset: synchronous active-low; counters, queue and handshakes clear, line store does not.
// Depends on hns_pkg, hns_front, hns_queue, hns_back.
`default_nettype none
module heightfield_normal_stencil_top
  import hns_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire                     cfg_index,
  input  wire  [CNT_BITS-1:0]     cfg_data,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire  [3*COORD_BITS-1:0] in_tdata,   // pos_x, pos_y, pos_z
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [3*NRM_BITS-1:0]   out_tdata,  // normal_x, normal_y, normal_z
  output logic                    out_tuser,  // degenerate
  output logic                    out_tlast
);

  logic [LEN_BITS-1:0] row_length_r, len;
  logic [CNT_BITS-1:0] row_count_r, rows;
  logic                q_push, q_full, q_pop, q_valid;
  cmd_t                q_in, q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= LEN_RESET;
      row_count_r  <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_LENGTH: row_length_r <= cfg_data[LEN_BITS-1:0];
        REG_ROW_COUNT:  row_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to the supported range
  assign len  = (row_length_r < LEN_MIN) ? LEN_MIN :
                (row_length_r > LEN_MAX) ? LEN_MAX : row_length_r;
  assign rows = (row_count_r < CNT_MIN) ? CNT_MIN :
                (row_count_r > CNT_MAX) ? CNT_MAX : row_count_r;

  hns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .len       (len),
    .rows      (rows),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_cmd     (q_in),
    .q_full    (q_full)
  );

  hns_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_out),
    .not_empty (q_valid)
  );

  hns_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/hns_queue.sv =====
// Small request queue between the stencil front and the normalize back.
// Depends on hns_pkg.
`default_nettype none
module hns_queue
  import hns_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  cmd_t push_cmd,
  output logic full,
  input  wire  pop,
  output cmd_t pop_cmd,
  output logic not_empty
);

  cmd_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_r, rp_r;
  logic [QPTR_BITS:0]   cnt_r;

  assign full      = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && not_empty) rp_r <= rp_r + 1'b1;
      if ((push && !full) && !(pop && not_empty)) cnt_r <= cnt_r + 1'b1;
      else if (!(push && !full) && (pop && not_empty)) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hns_front.sv =====
// Front part: accepts vertices, keeps the line store, forms the stencil vector.
// Depends on hns_pkg.
`default_nettype none
module hns_front
  import hns_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [LEN_BITS-1:0]   len,
  input  wire  [CNT_BITS-1:0]   rows,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [3*COORD_BITS-1:0] in_tdata,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  input  wire                   q_full
);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_RD1   = 5'b00010,
    F_RD2   = 5'b00100,
    F_CALC  = 5'b01000,
    F_FLUSH = 5'b10000
  } fstate_t;

  fstate_t                  state_r;
  logic [3*COORD_BITS-1:0]  mem_r [1<<PTR_BITS];
  logic [3*COORD_BITS-1:0]  rda_r, rdb_r, wlo_r, cur_r;
  logic [PTR_BITS-1:0]      wp_r, addr_c_r;
  logic [COL_BITS-1:0]      col_r;
  logic [ROW_BITS-1:0]      row_r;
  logic [LEN_BITS-1:0]      len_r, flush_cnt_r;
  logic                     interior_r, emit_r, flush_r;
  cmd_t                     cmd_r;

  logic                     accept;
  logic [PTR_BITS-1:0]      addr_a, addr_b;
  logic [LEN_BITS:0]        col_inc;
  logic [CNT_BITS-1:0]      row_inc;
  logic                     row_end, blk_end;

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid && in_tready;

  // read addresses: two rows back, and one of the two neighbors one row back
  assign addr_a  = wp_r - {len, 1'b0};
  assign addr_b  = wp_r - PTR_BITS'(len - 1'b1);
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign row_end = (col_inc >= {1'b0, len});
  assign blk_end = row_end && (row_inc >= rows);

  // line store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wp_r] <= in_tdata;
      rda_r       <= mem_r[addr_a];
      rdb_r       <= mem_r[addr_b];
    end else if (state_r == F_RD1) begin
      rdb_r       <= mem_r[addr_c_r];
    end
  end

  // stencil vector
  function automatic logic signed [VEC_BITS-1:0] ext(input logic [COORD_BITS-1:0] v);
    ext = {{(VEC_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r      <= in_tdata;
      addr_c_r   <= wp_r - PTR_BITS'(len + 1'b1);
      len_r      <= len;
      interior_r <= (row_r >= ROW_BITS'(2)) && (col_r != '0) && !row_end;
      emit_r     <= (row_r != '0);
      flush_r    <= blk_end;
    end
    if (state_r == F_RD1) begin
      wlo_r <= rdb_r;
    end
    if (state_r == F_RD2) begin
      cmd_r.up   <= !interior_r;
      cmd_r.last <= 1'b0;
      cmd_r.vx   <= ext(rda_r[2*COORD_BITS-1:COORD_BITS])
                  - ext(cur_r[2*COORD_BITS-1:COORD_BITS]);
      cmd_r.vy   <= ext(wlo_r[3*COORD_BITS-1:2*COORD_BITS])
                  - ext(rdb_r[3*COORD_BITS-1:2*COORD_BITS])
                  + ext(cur_r[COORD_BITS-1:0]) - ext(rda_r[COORD_BITS-1:0]);
      cmd_r.vz   <= ext(rdb_r[2*COORD_BITS-1:COORD_BITS])
                  - ext(wlo_r[2*COORD_BITS-1:COORD_BITS]);
    end
  end

  // queue push
  always_comb begin
    q_push = 1'b0;
    q_cmd  = cmd_r;
    unique case (state_r)
      F_CALC: begin
        q_push = emit_r;
      end
      F_FLUSH: begin
        q_push     = 1'b1;
        q_cmd      = '0;
        q_cmd.up   = 1'b1;
        q_cmd.last = (flush_cnt_r == LEN_BITS'(1));
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      wp_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      flush_cnt_r <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            wp_r    <= wp_r + 1'b1;
            state_r <= F_RD1;
            if (blk_end) begin
              col_r <= '0;
              row_r <= '0;
            end else if (row_end) begin
              col_r <= '0;
              row_r <= row_r + 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
            end
          end
        end
        F_RD1: state_r <= F_RD2;
        F_RD2: state_r <= F_CALC;
        F_CALC: begin
          if (!emit_r || !q_full) begin
            flush_cnt_r <= len_r;
            state_r     <= flush_r ? F_FLUSH : F_IDLE;
          end
        end
        F_FLUSH: begin
          if (!q_full) begin
            flush_cnt_r <= flush_cnt_r - 1'b1;
            if (flush_cnt_r == LEN_BITS'(1)) state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hns_back.sv =====
// Back part: scales a nonzero interior vector to unit length in Q1.14, holds the output.
// Depends on hns_pkg.
`default_nettype none
module hns_back
  import hns_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [3*NRM_BITS-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_SHIFT = 7'b0000010,
    B_SQ    = 7'b0000100,
    B_SUM   = 7'b0001000,
    B_ESQ   = 7'b0010000,
    B_CMP   = 7'b0100000,
    B_DONE  = 7'b1000000
  } bstate_t;

  bstate_t                 state_r;
  logic [VEC_BITS-1:0]     mag_r [3];
  logic [2*MAG_BITS-1:0]   sq_r  [3];
  logic [31:0]             esq_r [3];
  logic [UNIT_BITS-1:0]    m_r   [3];
  logic [2:0]              neg_r;
  logic [SUM_BITS-1:0]     s_r;
  logic [3:0]              bit_r;
  logic                    deg_r, last_r;
  logic                    out_valid_r, out_deg_r, out_last_r;
  logic [3*NRM_BITS-1:0]   out_data_r;

  logic                    zero_vec, too_big, out_free;
  logic [UNIT_BITS-1:0]    t    [3];
  logic [NRM_BITS-1:0]     e    [3];
  logic [61:0]             prod [3];
  logic [NRM_BITS-1:0]     res  [3];

  function automatic logic [VEC_BITS-1:0] absv(input logic signed [VEC_BITS-1:0] v);
    absv = v[VEC_BITS-1] ? VEC_BITS'(-v) : v;
  endfunction

  assign zero_vec = (q_cmd.vx == '0) && (q_cmd.vy == '0) && (q_cmd.vz == '0);
  assign too_big  = (|mag_r[0][VEC_BITS-1:MAG_BITS]) || (|mag_r[1][VEC_BITS-1:MAG_BITS])
                 || (|mag_r[2][VEC_BITS-1:MAG_BITS]);
  assign out_free = !out_valid_r || out_tready;
  assign q_pop    = (state_r == B_IDLE) && q_valid;

  // per-lane trial bit, square of the odd bound, product against the sum and signed result
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]    = m_r[i] | (UNIT_BITS'(1) << bit_r);
      e[i]    = {t[i], 1'b0} - 1'b1;
      prod[i] = 62'(esq_r[i]) * 62'(s_r);
      res[i]  = neg_r[i] ? NRM_BITS'(-{1'b0, m_r[i]}) : {1'b0, m_r[i]};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        mag_r[0] <= absv(q_cmd.vx);
        mag_r[1] <= absv(q_cmd.vy);
        mag_r[2] <= absv(q_cmd.vz);
        neg_r    <= {q_cmd.vz[VEC_BITS-1], q_cmd.vy[VEC_BITS-1], q_cmd.vx[VEC_BITS-1]};
        deg_r    <= !q_cmd.up;
        last_r   <= q_cmd.last;
        m_r[0]   <= '0;
        m_r[1]   <= ONE_Q14;
        m_r[2]   <= '0;
        if (!q_cmd.up && !zero_vec) deg_r <= 1'b0;
        if (q_cmd.up || zero_vec) neg_r <= '0;
      end
      B_SHIFT: begin
        if (too_big) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end
      end
      B_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sq_r[i] <= mag_r[i][MAG_BITS-1:0] * mag_r[i][MAG_BITS-1:0];
        end
      end
      B_SUM: begin
        s_r   <= SUM_BITS'(sq_r[0]) + SUM_BITS'(sq_r[1]) + SUM_BITS'(sq_r[2]);
        bit_r <= 4'd14;
        for (int i = 0; i < 3; i++) m_r[i] <= '0;
      end
      B_ESQ: begin
        for (int i = 0; i < 3; i++) esq_r[i] <= e[i] * e[i];
      end
      B_CMP: begin
        for (int i = 0; i < 3; i++) begin
          if (prod[i] <= {4'b0, sq_r[i], 30'b0}) m_r[i] <= t[i];
        end
        bit_r <= bit_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) state_r <= (q_cmd.up || zero_vec) ? B_DONE : B_SHIFT;
        end
        B_SHIFT: if (!too_big) state_r <= B_SQ;
        B_SQ:    state_r <= B_SUM;
        B_SUM:   state_r <= B_ESQ;
        B_ESQ:   state_r <= B_CMP;
        B_CMP:   state_r <= (bit_r == '0) ? B_DONE : B_ESQ;
        B_DONE:  if (out_free) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == B_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_DONE && out_free) begin
      out_data_r <= {res[2], res[1], res[0]};
      out_deg_r  <= deg_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_deg_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
